// ----- sv/tlde_pkg.sv -----
// Shared constants and opcode codes for the tree ancestor and distance engine.
package tlde_pkg;

	localparam int MAX_NODES_DEF   = 4096;
	localparam int LIFT_LEVELS_DEF = 12;
	localparam int MAX_POINTS_DEF  = 8192;

	// Wide enough for any node count or id compare over the parameter ranges.
	localparam int CNT_W  = 17;
	localparam int ID1_W  = 13;
	localparam int ID2_W  = 12;
	localparam int DEP_W  = 12;
	localparam int DIST_W = 32;
	localparam int TDST_W = 33;
	localparam int ANC_W  = 12;
	localparam int CFG_W  = 13;
	localparam int OP_W   = 3;

	localparam logic [OP_W-1:0] OP_LOAD_NODE  = 3'd0;
	localparam logic [OP_W-1:0] OP_BUILD      = 3'd1;
	localparam logic [OP_W-1:0] OP_QRY_NODES  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOAD_POINT = 3'd3;
	localparam logic [OP_W-1:0] OP_QRY_POINTS = 3'd4;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

endpackage

// ----- sv/tlde_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module tlde_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/tree_lca_distance_engine_top.sv -----
// Top level: command sequencer around the ancestor, depth, distance and point memories.
//
// The engine holds a rooted tree in on-chip RAM and answers lowest common ancestor and
// tree distance queries by binary lifting. A node or point load passes through a
// dispatch state after acceptance before the input is ready again. A node query reads
// the depths and root distances of both nodes, lifts the deeper node to the depth of the
// other, and, when the two nodes still differ, climbs both jointly level by level and
// reads the final parent; it then reads the root distance of the ancestor. A point query
// first looks up the leaf node of each point. The single read port of the ancestor
// memory serializes these steps. A table build fills every level above zero for every
// node, one node at a time. A finished result waits in the sequencer until the output
// register is free; a new word is accepted once the sequencer is back in idle.
module tree_lca_distance_engine_top #(
	parameter int MAX_NODES   = tlde_pkg::MAX_NODES_DEF,
	parameter int LIFT_LEVELS = tlde_pkg::LIFT_LEVELS_DEF,
	parameter int MAX_POINTS  = tlde_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlde_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tlde_pkg::OP_W-1:0]     opcode,
	input  logic [tlde_pkg::ID1_W-1:0]    first_id,
	input  logic [tlde_pkg::ID2_W-1:0]    second_id,
	input  logic [tlde_pkg::DEP_W-1:0]    node_depth_in,
	input  logic [tlde_pkg::DIST_W-1:0]   root_dist_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tlde_pkg::ANC_W-1:0]    ancestor_node,
	output logic [tlde_pkg::TDST_W-1:0]   tree_distance,
	output logic                          status
);
	import tlde_pkg::*;

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int LW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int GW = ((LIFT_LEVELS > DEP_W) ? LIFT_LEVELS : DEP_W) + 1;
	localparam int AAW = LW + NW;
	localparam logic [LW-1:0] TOP_LVL = LW'(LIFT_LEVELS - 1);
	localparam logic [CNT_W-1:0] NODES_C  = CNT_W'(MAX_NODES);
	localparam logic [CNT_W-1:0] POINTS_C = CNT_W'(MAX_POINTS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_PT_A, ST_PT_B, ST_ND_A, ST_ND_B, ST_ND_C,
		ST_UP, ST_UP_W, ST_CMP, ST_JP, ST_JP_A, ST_JP_B, ST_FIN, ST_FIN_W,
		ST_DST, ST_DST_W, ST_RES, ST_BLD, ST_BLD_A, ST_BLD_B
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    node_count_q;
	logic [OP_W-1:0]     op_q;
	logic [ID1_W-1:0]    id1_q;
	logic [ID2_W-1:0]    id2_q;
	logic [DEP_W-1:0]    dep_in_q;
	logic [DIST_W-1:0]   dist_in_q;
	logic [NW-1:0]       a_q, b_q, na_q, lca_q;
	logic [DEP_W-1:0]    da_q;
	logic [GW-1:0]       gap_q;
	logic [LW-1:0]       lvl_q;
	logic [CNT_W-1:0]    bi_q;
	logic [TDST_W-1:0]   dsum_q, dist_q;
	logic                fault_q;
	logic [ANC_W-1:0]    anc_out_q;
	logic [TDST_W-1:0]   tdst_out_q;
	logic                status_q;
	logic                out_valid_q;

	logic [CNT_W-1:0]    cnt, id1_x, id2_x, ra_x, rb_x;
	logic                node_bad, point_bad, leaf_bad, take;
	logic [GW-1:0]       step;
	logic [TDST_W-1:0]   two_w;

	logic                anc_we;
	logic [AAW-1:0]      anc_waddr, anc_raddr;
	logic [NW-1:0]       anc_wdata, anc_rd;
	logic                nd_we;
	logic [NW-1:0]       nd_raddr;
	logic [DEP_W-1:0]    dep_rd;
	logic [DIST_W-1:0]   dst_rd;
	logic                pt_we;
	logic [PW-1:0]       pt_raddr;
	logic [NW-1:0]       pt_rd;

	assign cnt   = (CNT_W'(node_count_q) > NODES_C) ? NODES_C : CNT_W'(node_count_q);
	assign id1_x = CNT_W'(id1_q);
	assign id2_x = CNT_W'(id2_q);
	assign ra_x  = CNT_W'(a_q);
	assign rb_x  = CNT_W'(pt_rd);
	assign node_bad  = (id1_x >= cnt) || (id2_x >= cnt);
	assign point_bad = (id1_x >= POINTS_C) || (id2_x >= POINTS_C);
	assign leaf_bad  = (ra_x >= cnt) || (rb_x >= cnt);
	assign step  = GW'(1) << lvl_q;
	assign take  = gap_q >= step;
	assign two_w = {dst_rd, 1'b0};

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign ancestor_node = anc_out_q;
	assign tree_distance = tdst_out_q;
	assign status        = status_q;

	// Memory port steering per sequencer state.
	always_comb begin
		anc_we    = 1'b0;
		anc_waddr = {lvl_q, b_q};
		anc_wdata = anc_rd;
		anc_raddr = {lvl_q, a_q};
		nd_we     = 1'b0;
		nd_raddr  = a_q;
		pt_we     = 1'b0;
		pt_raddr  = id1_x[PW-1:0];
		unique case (state_q)
			ST_DISP: begin
				if (op_q == OP_LOAD_NODE && !node_bad) begin
					anc_we    = 1'b1;
					anc_waddr = {LW'(0), id1_x[NW-1:0]};
					anc_wdata = id2_x[NW-1:0];
					nd_we     = 1'b1;
				end
				if (op_q == OP_LOAD_POINT && (id1_x < POINTS_C) && (id2_x < cnt)) begin
					pt_we = 1'b1;
				end
			end
			ST_PT_A:  pt_raddr = id2_x[PW-1:0];
			ST_ND_B:  nd_raddr = b_q;
			ST_JP_A:  anc_raddr = {lvl_q, b_q};
			ST_FIN:   anc_raddr = {LW'(0), a_q};
			ST_DST:   nd_raddr = lca_q;
			ST_BLD:   anc_raddr = {lvl_q - LW'(1), bi_q[NW-1:0]};
			ST_BLD_A: anc_raddr = {lvl_q - LW'(1), anc_rd};
			ST_BLD_B: begin
				anc_we    = 1'b1;
				anc_waddr = {lvl_q, bi_q[NW-1:0]};
				anc_wdata = anc_rd;
			end
			default: ;
		endcase
	end

	tlde_ram #(.DEPTH(1 << AAW), .WIDTH(NW)) u_anc (
		.clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
		.raddr(anc_raddr), .rdata(anc_rd)
	);

	tlde_ram #(.DEPTH(MAX_NODES), .WIDTH(DEP_W), .AW(NW)) u_dep (
		.clk(clk), .we(nd_we), .waddr(id1_x[NW-1:0]), .wdata(dep_in_q),
		.raddr(nd_raddr), .rdata(dep_rd)
	);

	tlde_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W), .AW(NW)) u_dst (
		.clk(clk), .we(nd_we), .waddr(id1_x[NW-1:0]), .wdata(dist_in_q),
		.raddr(nd_raddr), .rdata(dst_rd)
	);

	tlde_ram #(.DEPTH(MAX_POINTS), .WIDTH(NW), .AW(PW)) u_pt (
		.clk(clk), .we(pt_we), .waddr(id1_x[PW-1:0]), .wdata(id2_x[NW-1:0]),
		.raddr(pt_raddr), .rdata(pt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= CFG_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			// The result state loads the output register itself.
			if (out_valid_q && out_ready && state_q != ST_RES) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q      <= opcode;
						id1_q     <= first_id;
						id2_q     <= second_id;
						dep_in_q  <= node_depth_in;
						dist_in_q <= root_dist_in;
						state_q   <= ST_DISP;
					end
				end
				ST_DISP: begin
					fault_q <= 1'b1;
					a_q     <= id1_x[NW-1:0];
					b_q     <= id2_x[NW-1:0];
					case (op_q)
						OP_LOAD_NODE:  state_q <= node_bad ? ST_RES : ST_IDLE;
						OP_LOAD_POINT:
							state_q <= (point_bad || id2_x >= cnt) ? ST_RES : ST_IDLE;
						OP_QRY_NODES:  state_q <= node_bad ? ST_RES : ST_ND_A;
						OP_QRY_POINTS: state_q <= point_bad ? ST_RES : ST_PT_A;
						OP_BUILD: begin
							lvl_q   <= LW'(1);
							bi_q    <= '0;
							state_q <= (cnt == '0 || LIFT_LEVELS < 2) ? ST_IDLE : ST_BLD;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_PT_A: begin
					a_q     <= pt_rd;
					state_q <= ST_PT_B;
				end
				ST_PT_B: begin
					b_q     <= pt_rd;
					state_q <= leaf_bad ? ST_RES : ST_ND_A;
				end
				ST_ND_A: state_q <= ST_ND_B;
				ST_ND_B: begin
					da_q    <= dep_rd;
					dsum_q  <= TDST_W'(dst_rd);
					state_q <= ST_ND_C;
				end
				ST_ND_C: begin
					dsum_q <= dsum_q + TDST_W'(dst_rd);
					// Lift the deeper of the two nodes; a stays the deeper one.
					if (da_q < dep_rd) begin
						a_q   <= b_q;
						b_q   <= a_q;
						gap_q <= GW'(dep_rd - da_q);
					end else begin
						gap_q <= GW'(da_q - dep_rd);
					end
					lvl_q   <= TOP_LVL;
					state_q <= ST_UP;
				end
				ST_UP: begin
					if (take) begin
						state_q <= ST_UP_W;
					end else if (lvl_q == '0) begin
						state_q <= ST_CMP;
					end else begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				ST_UP_W: begin
					a_q   <= anc_rd;
					gap_q <= gap_q - step;
					if (lvl_q == '0) begin
						state_q <= ST_CMP;
					end else begin
						lvl_q   <= lvl_q - LW'(1);
						state_q <= ST_UP;
					end
				end
				ST_CMP: begin
					lvl_q <= TOP_LVL;
					if (a_q == b_q) begin
						lca_q   <= a_q;
						state_q <= ST_DST;
					end else begin
						state_q <= ST_JP;
					end
				end
				ST_JP: state_q <= ST_JP_A;
				ST_JP_A: begin
					na_q    <= anc_rd;
					state_q <= ST_JP_B;
				end
				ST_JP_B: begin
					if (na_q != anc_rd) begin
						a_q <= na_q;
						b_q <= anc_rd;
					end
					if (lvl_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						lvl_q   <= lvl_q - LW'(1);
						state_q <= ST_JP;
					end
				end
				ST_FIN: state_q <= ST_FIN_W;
				ST_FIN_W: begin
					lca_q   <= anc_rd;
					state_q <= ST_DST;
				end
				ST_DST: state_q <= ST_DST_W;
				ST_DST_W: begin
					// A negative distance from inconsistent loads saturates to zero.
					dist_q  <= (dsum_q >= two_w) ? dsum_q - two_w : '0;
					fault_q <= 1'b0;
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= fault_q ? STATUS_BAD : STATUS_OK;
						anc_out_q   <= fault_q ? '0 : ANC_W'(lca_q);
						tdst_out_q  <= fault_q ? '0 : dist_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_BLD: state_q <= ST_BLD_A;
				ST_BLD_A: state_q <= ST_BLD_B;
				ST_BLD_B: begin
					if (bi_q + CNT_W'(1) == cnt) begin
						bi_q <= '0;
						if (lvl_q == TOP_LVL) begin
							state_q <= ST_IDLE;
						end else begin
							lvl_q   <= lvl_q + LW'(1);
							state_q <= ST_BLD;
						end
					end else begin
						bi_q    <= bi_q + CNT_W'(1);
						state_q <= ST_BLD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
